[hw/rtl/wsp_pkg.sv]
// shared types, constants and a helper function for the weighted sample predictor
`default_nettype none

package wsp_pkg;

   // sample and field widths
   localparam int SAMPLE_BITS = 8;
   localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
   localparam int DIST_BITS   = 17;
   localparam int CLIP_BITS   = 8;
   localparam int PARAM_BITS  = 8;
   localparam int DEN_BITS    = 3;
   localparam int USED_BITS   = 2;
   localparam int MODE_BITS   = 2;

   // stream packing
   localparam int REQ_FIELD_BITS = 2 * SAMPLE_BITS + 4 * PARAM_BITS + DEN_BITS
                                   + 2 * DIST_BITS + 1;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int REQ_USER_BITS  = USED_BITS + MODE_BITS;
   localparam int RSP_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

   // implicit weight constants
   localparam int DIST_MAX       = 127;
   localparam int DIST_MIN       = -128;
   localparam int IMPLICIT_NUMER = 16384;
   localparam int DSF_MAX        = 1023;
   localparam int DSF_MIN        = -1024;
   localparam int W1_MIN         = -64;
   localparam int W1_MAX         = 128;
   localparam int W1_FALLBACK    = 32;
   localparam int WEIGHT_SUM     = 64;
   localparam int WEIGHT_SHIFT   = 6;
   localparam int WEIGHT_ROUND   = 32;

   // divider layout: quotient bits resolved per pipeline stage
   localparam int QUOT_BITS          = 16;
   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int DIV_STAGES         = QUOT_BITS / DIV_BITS_PER_STAGE;
   localparam int MAG_BITS           = CLIP_BITS;

   // datapath widths after the weight stage
   localparam int COEF_BITS  = PARAM_BITS + 1;
   localparam int DSF_BITS   = 11;
   localparam int PROD_BITS  = CLIP_BITS + QUOT_BITS;
   localparam int SHIFT_BITS = DEN_BITS + 1;
   localparam int TERM_BITS  = COEF_BITS + SAMPLE_BITS + 1;
   localparam int SUM_BITS   = TERM_BITS + 1;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_DEFAULT  = 2'd0,
      MODE_EXPLICIT = 2'd1,
      MODE_IMPLICIT = 2'd2,
      MODE_RESERVED = 2'd3
   } mode_type;

   // request fields as unpacked from the stream
   typedef struct packed {
      logic [SAMPLE_BITS-1:0]       s0;
      logic [SAMPLE_BITS-1:0]       s1;
      logic [USED_BITS-1:0]         used;
      mode_type                     mode;
      logic signed [PARAM_BITS-1:0] w0;
      logic signed [PARAM_BITS-1:0] w1;
      logic signed [PARAM_BITS-1:0] o0;
      logic signed [PARAM_BITS-1:0] o1;
      logic [DEN_BITS-1:0]          den;
      logic signed [DIST_BITS-1:0]  ref_dist;
      logic signed [DIST_BITS-1:0]  cur_dist;
      logic                         short_both;
   } req_type;

   // per-sample payload carried alongside the divider
   typedef struct packed {
      logic [SAMPLE_BITS-1:0]       s0;
      logic [SAMPLE_BITS-1:0]       s1;
      logic [USED_BITS-1:0]         used;
      mode_type                     mode;
      logic signed [PARAM_BITS-1:0] w0;
      logic signed [PARAM_BITS-1:0] w1;
      logic signed [PARAM_BITS-1:0] o0;
      logic signed [PARAM_BITS-1:0] o1;
      logic [DEN_BITS-1:0]          den;
      logic signed [CLIP_BITS-1:0]  tb;
      logic                         implicit_ok;
   } item_type;

   // restoring divider state
   typedef struct packed {
      logic [MAG_BITS-1:0]  divisor;
      logic                 neg;
      logic [MAG_BITS-1:0]  rem;
      logic [QUOT_BITS-1:0] num;
      logic [QUOT_BITS-1:0] quo;
   } div_type;

   // generic weighted sum: ((a*s0 + b*s1 + rnd) >>> sh) + off
   typedef struct packed {
      logic signed [COEF_BITS-1:0]  a;
      logic signed [COEF_BITS-1:0]  b;
      logic [PARAM_BITS-1:0]        rnd;
      logic [SHIFT_BITS-1:0]        sh;
      logic signed [PARAM_BITS-1:0] off;
      logic [SAMPLE_BITS-1:0]       s0;
      logic [SAMPLE_BITS-1:0]       s1;
   } ctrl_type;

   // clip a picture order distance to the signed 8-bit range
   function automatic logic signed [CLIP_BITS-1:0] clip_dist(
      input logic signed [DIST_BITS-1:0] d);
      logic signed [CLIP_BITS-1:0] r;
      if (d > DIST_MAX) begin
         r = CLIP_BITS'(DIST_MAX);
      end else if (d < DIST_MIN) begin
         r = CLIP_BITS'(DIST_MIN);
      end else begin
         r = d[CLIP_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/weighted_sample_predictor_core.sv]
// top level of the weighted sample predictor: stream ports and stage chain
//
// Combines one or two interpolated 8-bit prediction samples into the final
// predicted sample (default average, explicit weighted, implicit weighted).
// Requests arrive on the req_ channel, one predicted sample per request
// leaves on the rsp_ channel, in request order.
// Ten register stages (input setup, four divider stages of four
// quotient bits each, scale factor, coefficient select, products, sum,
// shift/clip output register). Throughput: one request per clock sustained
// while rsp_tready stays high; the reciprocal divider is fully pipelined, so
// nothing is shared between requests.
// Every stage carries its own valid bit and moves when it is empty or when
// the stage after it moves, so bubbles are squeezed out and new requests
// are taken while a finished result waits on rsp_tready. Once all stages
// are full and rsp_tready is low, req_tready falls; nothing is dropped.
// Reset (synchronous, active high) empties every stage; the block holds no
// other state.
`default_nettype none

module weighted_sample_predictor_core import wsp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // sample_list0, sample_list1, weight_list0, weight_list1, offset_list0,
   // offset_list1, log_denom, ref_distance, cur_distance, both_short_term
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // lists_used, mode
   input  logic [REQ_USER_BITS-1:0] req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // predicted_sample
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int S1_LO  = SAMPLE_BITS;
   localparam int W0_LO  = 2 * SAMPLE_BITS;
   localparam int W1_LO  = W0_LO + PARAM_BITS;
   localparam int O0_LO  = W1_LO + PARAM_BITS;
   localparam int O1_LO  = O0_LO + PARAM_BITS;
   localparam int DEN_LO = O1_LO + PARAM_BITS;
   localparam int REF_LO = DEN_LO + DEN_BITS;
   localparam int CUR_LO = REF_LO + DIST_BITS;
   localparam int STB_LO = CUR_LO + DIST_BITS;

   req_type                req;
   logic                   front_valid, front_ready;
   item_type               front_item;
   div_type                front_div;
   logic                   div_valid, div_ready;
   item_type               div_item;
   div_type                div_res;
   logic                   wgt_valid, wgt_ready;
   ctrl_type               wgt_ctrl;
   logic [SAMPLE_BITS-1:0] sample;

   // unpack request fields
   always_comb begin
      req.s0         = req_tdata[S1_LO-1:0];
      req.s1         = req_tdata[W0_LO-1:S1_LO];
      req.w0         = req_tdata[W1_LO-1:W0_LO];
      req.w1         = req_tdata[O0_LO-1:W1_LO];
      req.o0         = req_tdata[O1_LO-1:O0_LO];
      req.o1         = req_tdata[DEN_LO-1:O1_LO];
      req.den        = req_tdata[REF_LO-1:DEN_LO];
      req.ref_dist   = req_tdata[CUR_LO-1:REF_LO];
      req.cur_dist   = req_tdata[STB_LO-1:CUR_LO];
      req.short_both = req_tdata[STB_LO];
      req.used       = req_tuser[USED_BITS-1:0];
      req.mode       = mode_type'(req_tuser[REQ_USER_BITS-1:USED_BITS]);
   end

   wsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_req    (req),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item),
      .out_div   (front_div)
   );

   wsp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .in_div    (front_div),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item),
      .out_div   (div_res)
   );

   wsp_weight u_weight (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_item   (div_item),
      .in_div    (div_res),
      .out_valid (wgt_valid),
      .out_ready (wgt_ready),
      .out_ctrl  (wgt_ctrl)
   );

   wsp_combine u_combine (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (wgt_valid),
      .in_ready   (wgt_ready),
      .in_ctrl    (wgt_ctrl),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sample (sample)
   );

   assign rsp_tdata = RSP_DATA_BITS'(sample);

endmodule

`default_nettype wire

[hw/rtl/wsp_front.sv]
// input stage: distance clipping and divider operand setup
`default_nettype none

module wsp_front import wsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_req,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item,
   output div_type  out_div
);

   logic                        en;
   logic                        valid_ff;
   logic signed [CLIP_BITS-1:0] td;
   logic [MAG_BITS-1:0]         mag;
   item_type                    item_in, item_ff;
   div_type                     div_in, div_ff;

   assign en       = ~valid_ff | out_ready;
   assign in_ready = en;

   // clip distances and build the numerator 16384 + |td/2|
   always_comb begin
      td  = clip_dist(in_req.ref_dist);
      mag = td[CLIP_BITS-1] ? MAG_BITS'(-td) : MAG_BITS'(td);

      item_in.s0          = in_req.s0;
      item_in.s1          = in_req.s1;
      item_in.used        = in_req.used;
      item_in.mode        = in_req.mode;
      item_in.w0          = in_req.w0;
      item_in.w1          = in_req.w1;
      item_in.o0          = in_req.o0;
      item_in.o1          = in_req.o1;
      item_in.den         = in_req.den;
      item_in.tb          = clip_dist(in_req.cur_dist);
      item_in.implicit_ok = (td != '0) && in_req.short_both;

      div_in.divisor = mag;
      div_in.neg     = td[CLIP_BITS-1];
      div_in.rem     = '0;
      div_in.num     = QUOT_BITS'(IMPLICIT_NUMER) + QUOT_BITS'(mag >> 1);
      div_in.quo     = '0;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
         div_ff  <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_div   = div_ff;

endmodule

`default_nettype wire

[hw/rtl/wsp_divider.sv]
// pipelined restoring divider for the implicit weight reciprocal
`default_nettype none

module wsp_divider import wsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  div_type  in_div,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item,
   output div_type  out_div
);

   logic [DIV_STAGES-1:0] en;
   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_src;
   item_type              item_src [DIV_STAGES];
   item_type              item_ff  [DIV_STAGES];
   div_type               div_src  [DIV_STAGES];
   div_type               div_in   [DIV_STAGES];
   div_type               div_ff   [DIV_STAGES];

   // one shift-compare-subtract per quotient bit
   function automatic div_type div_steps(input div_type d);
      div_type         r;
      logic [MAG_BITS:0] part;
      r = d;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         part  = {r.rem, r.num[QUOT_BITS-1]};
         r.num = {r.num[QUOT_BITS-2:0], 1'b0};
         if (part >= {1'b0, r.divisor}) begin
            r.rem = MAG_BITS'(part - {1'b0, r.divisor});
            r.quo = {r.quo[QUOT_BITS-2:0], 1'b1};
         end else begin
            r.rem = part[MAG_BITS-1:0];
            r.quo = {r.quo[QUOT_BITS-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // per-stage enables, a stage moves when empty or when the next one moves
   always_comb begin
      en[DIV_STAGES-1] = ~valid_ff[DIV_STAGES-1] | out_ready;
      for (int k = DIV_STAGES - 2; k >= 0; k--) begin
         en[k] = ~valid_ff[k] | en[k+1];
      end
   end

   assign in_ready = en[0];

   // stage sources
   always_comb begin
      valid_src[0] = in_valid;
      item_src[0]  = in_item;
      div_src[0]   = in_div;
      for (int k = 1; k < DIV_STAGES; k++) begin
         valid_src[k] = valid_ff[k-1];
         item_src[k]  = item_ff[k-1];
         div_src[k]   = div_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         div_in[k] = div_steps(div_src[k]);
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_src[k];
            end
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (en[k]) begin
            item_ff[k] <= item_src[k];
            div_ff[k]  <= div_in[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_item  = item_ff[DIV_STAGES-1];
   assign out_div   = div_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

[hw/rtl/wsp_weight.sv]
// weight stages: implicit scale factor and per-mode coefficient selection
`default_nettype none

module wsp_weight import wsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  div_type  in_div,
   output logic     out_valid,
   input  logic     out_ready,
   output ctrl_type out_ctrl
);

   logic                         en_e, en_f;
   logic                         valid_e_ff, valid_f_ff;
   logic signed [QUOT_BITS-1:0]  tx;
   logic signed [PROD_BITS-1:0]  prod_in, prod_ff;
   item_type                     item_e_ff;
   logic signed [PROD_BITS-1:0]  scaled;
   logic signed [DSF_BITS-1:0]   dsf;
   logic signed [COEF_BITS-1:0]  q2;
   logic signed [COEF_BITS-1:0]  iw1, iw0;
   logic signed [PARAM_BITS:0]   osum;
   logic                         u0, u1;
   ctrl_type                     ctrl_in, ctrl_ff;

   assign en_f     = ~valid_f_ff | out_ready;
   assign en_e     = ~valid_e_ff | en_f;
   assign in_ready = en_e;

   // signed reciprocal times clipped current distance
   always_comb begin
      tx      = in_div.neg ? -$signed(in_div.quo) : $signed(in_div.quo);
      prod_in = PROD_BITS'(in_item.tb) * PROD_BITS'(tx);
   end

   // implicit weight with fallback, then coefficients for the shared sum
   always_comb begin
      scaled = (prod_ff + PROD_BITS'(WEIGHT_ROUND)) >>> WEIGHT_SHIFT;
      if (scaled > DSF_MAX) begin
         dsf = DSF_BITS'(DSF_MAX);
      end else if (scaled < DSF_MIN) begin
         dsf = DSF_BITS'(DSF_MIN);
      end else begin
         dsf = scaled[DSF_BITS-1:0];
      end
      q2 = dsf[DSF_BITS-1:2];
      if (item_e_ff.implicit_ok && q2 >= W1_MIN && q2 <= W1_MAX) begin
         iw1 = q2;
      end else begin
         iw1 = COEF_BITS'(W1_FALLBACK);
      end
      iw0  = COEF_BITS'(WEIGHT_SUM) - iw1;
      osum = (PARAM_BITS + 1)'(item_e_ff.o0) + (PARAM_BITS + 1)'(item_e_ff.o1)
             + (PARAM_BITS + 1)'(1);
      u0   = item_e_ff.used[0];
      u1   = item_e_ff.used[1];

      // default: pass-through or rounded average
      ctrl_in.s0  = item_e_ff.s0;
      ctrl_in.s1  = item_e_ff.s1;
      ctrl_in.off = '0;
      if (u0 && u1) begin
         ctrl_in.a   = COEF_BITS'(1);
         ctrl_in.b   = COEF_BITS'(1);
         ctrl_in.rnd = PARAM_BITS'(1);
         ctrl_in.sh  = SHIFT_BITS'(1);
      end else begin
         ctrl_in.a   = u0 ? COEF_BITS'(1) : '0;
         ctrl_in.b   = u0 ? '0 : COEF_BITS'(1);
         ctrl_in.rnd = '0;
         ctrl_in.sh  = '0;
      end

      unique case (item_e_ff.mode)
         MODE_EXPLICIT: begin
            if (u0 && u1) begin
               ctrl_in.a   = COEF_BITS'(item_e_ff.w0);
               ctrl_in.b   = COEF_BITS'(item_e_ff.w1);
               ctrl_in.rnd = PARAM_BITS'(1) << item_e_ff.den;
               ctrl_in.sh  = {1'b0, item_e_ff.den} + SHIFT_BITS'(1);
               ctrl_in.off = osum[PARAM_BITS:1];
            end else begin
               ctrl_in.a   = u0 ? COEF_BITS'(item_e_ff.w0) : '0;
               ctrl_in.b   = u0 ? '0 : COEF_BITS'(item_e_ff.w1);
               ctrl_in.rnd = (item_e_ff.den == '0) ? '0 :
                             PARAM_BITS'(1) << (item_e_ff.den - DEN_BITS'(1));
               ctrl_in.sh  = {1'b0, item_e_ff.den};
               ctrl_in.off = u0 ? item_e_ff.o0 : item_e_ff.o1;
            end
         end
         MODE_IMPLICIT: begin
            if (u0 && u1) begin
               ctrl_in.a   = iw0;
               ctrl_in.b   = iw1;
               ctrl_in.rnd = PARAM_BITS'(WEIGHT_ROUND);
               ctrl_in.sh  = SHIFT_BITS'(WEIGHT_SHIFT);
            end
         end
         default: begin
         end
      endcase

      // no list used gives zero
      if (!u0 && !u1) begin
         ctrl_in.a   = '0;
         ctrl_in.b   = '0;
         ctrl_in.rnd = '0;
         ctrl_in.sh  = '0;
         ctrl_in.off = '0;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_e_ff <= 1'b0;
         valid_f_ff <= 1'b0;
      end else begin
         if (en_e) begin
            valid_e_ff <= in_valid;
         end
         if (en_f) begin
            valid_f_ff <= valid_e_ff;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en_e) begin
         item_e_ff <= in_item;
         prod_ff   <= prod_in;
      end
      if (en_f) begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign out_valid = valid_f_ff;
   assign out_ctrl  = ctrl_ff;

endmodule

`default_nettype wire

[hw/rtl/wsp_combine.sv]
// weighted sum stages: products, rounding sum, shift, offset and clip
`default_nettype none

module wsp_combine import wsp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ctrl_type               in_ctrl,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [SAMPLE_BITS-1:0] out_sample
);

   logic                         en_g, en_h, en_o;
   logic                         valid_g_ff, valid_h_ff, valid_o_ff;
   logic signed [TERM_BITS-1:0]  p0_in, p1_in, p0_ff, p1_ff;
   logic [PARAM_BITS-1:0]        rnd_g_ff;
   logic [SHIFT_BITS-1:0]        sh_g_ff, sh_h_ff;
   logic signed [PARAM_BITS-1:0] off_g_ff, off_h_ff;
   logic signed [SUM_BITS-1:0]   sum_in, sum_ff;
   logic signed [SUM_BITS-1:0]   shifted;
   logic signed [SUM_BITS:0]     total;
   logic [SAMPLE_BITS-1:0]       sample_in, sample_ff;

   assign en_o     = ~valid_o_ff | out_ready;
   assign en_h     = ~valid_h_ff | en_o;
   assign en_g     = ~valid_g_ff | en_h;
   assign in_ready = en_g;

   // coefficient times sample for each list
   always_comb begin
      p0_in = TERM_BITS'(in_ctrl.a) * TERM_BITS'($signed({1'b0, in_ctrl.s0}));
      p1_in = TERM_BITS'(in_ctrl.b) * TERM_BITS'($signed({1'b0, in_ctrl.s1}));
   end

   // products plus rounding term
   assign sum_in = SUM_BITS'(p0_ff) + SUM_BITS'(p1_ff)
                   + SUM_BITS'($signed({1'b0, rnd_g_ff}));

   // floor shift, offset and clip to the sample range
   always_comb begin
      shifted = sum_ff >>> sh_h_ff;
      total   = (SUM_BITS + 1)'(shifted) + (SUM_BITS + 1)'(off_h_ff);
      if (total < 0) begin
         sample_in = '0;
      end else if (total > SAMPLE_MAX) begin
         sample_in = SAMPLE_BITS'(SAMPLE_MAX);
      end else begin
         sample_in = total[SAMPLE_BITS-1:0];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_g_ff <= 1'b0;
         valid_h_ff <= 1'b0;
         valid_o_ff <= 1'b0;
      end else begin
         if (en_g) begin
            valid_g_ff <= in_valid;
         end
         if (en_h) begin
            valid_h_ff <= valid_g_ff;
         end
         if (en_o) begin
            valid_o_ff <= valid_h_ff;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en_g) begin
         p0_ff    <= p0_in;
         p1_ff    <= p1_in;
         rnd_g_ff <= in_ctrl.rnd;
         sh_g_ff  <= in_ctrl.sh;
         off_g_ff <= in_ctrl.off;
      end
      if (en_h) begin
         sum_ff   <= sum_in;
         sh_h_ff  <= sh_g_ff;
         off_h_ff <= off_g_ff;
      end
      if (en_o) begin
         sample_ff <= sample_in;
      end
   end

   assign out_valid  = valid_o_ff;
   assign out_sample = sample_ff;

endmodule

`default_nettype wire

[hw/rtl/wsp_checker.sv]
// port-level checks for the weighted sample predictor, bound to the top level
`default_nettype none

module wsp_checker import wsp_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // an empty output stage lets every stage move, so a request is taken
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("request refused while output stage is empty");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("stalled result withdrawn");

   // a stalled result keeps its value
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind weighted_sample_predictor_core wsp_checker u_wsp_checker (.*);

`default_nettype wire
